FILE: src/gsb_pkg.sv
package gsb_pkg;

    // field widths
    localparam int ADDR_W     = 40;
    localparam int SIZE_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // granule index within a zone: zone / granule is always 64K entries
    localparam int IDX_W = 16;

    // granule and zone sizes at the smallest zone mode, as shift counts
    localparam int GRAN_SHIFT_MIN = 16;
    localparam int ZONE_SHIFT_MIN = 32;

    // base of the remap window
    localparam logic [ADDR_W:0] REMAP_BASE = 41'h0_E000_0000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN1_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN1_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN2_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN2_END   = 3'd5;

    // zone mode codes
    localparam logic [1:0] ZM_64K  = 2'd0;
    localparam logic [1:0] ZM_128K = 2'd1;
    localparam logic [1:0] ZM_256K = 2'd2;
    localparam logic [1:0] ZM_NONE = 2'd3;

    // shift mode codes
    localparam logic [1:0] SM_NONE = 2'd0;
    localparam logic [1:0] SM_WIN1 = 2'd1;
    localparam logic [1:0] SM_WIN2 = 2'd2;

    typedef enum logic [1:0] {
        FN_SET = 2'd0,
        FN_CLR = 2'd1,
        FN_CHK = 2'd2,
        FN_BAD = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_MISALIGN = 3'd1,
        STS_RANGE    = 3'd2,
        STS_CHKFAIL  = 3'd3,
        STS_BADOP    = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]        zone_mode;
        logic [1:0]        shift_mode;
        logic [ADDR_W-1:0] win1_start;
        logic [ADDR_W-1:0] win1_end;
        logic [ADDR_W-1:0] win2_start;
        logic [ADDR_W-1:0] win2_end;
    } cfg_t;

    // range calculator to control
    typedef struct packed {
        logic    done;
        logic    reject;
        status_t status;
    } calc_stat_t;

    // bitmap walker to control
    typedef struct packed {
        logic clearing;
        logic done;
        logic fail;
    } walk_stat_t;

endpackage

FILE: src/gsb_req_if.sv
interface gsb_req_if;
    import gsb_pkg::*;

    logic              valid;
    logic              ready;
    func_t             func;
    logic [ADDR_W-1:0] phys_addr;
    logic [SIZE_W-1:0] size_bytes;

    modport source (output valid, func, phys_addr, size_bytes, input ready);
    modport sink (input valid, func, phys_addr, size_bytes, output ready);
endinterface

FILE: src/gsb_rsp_if.sv
interface gsb_rsp_if;
    import gsb_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;

    modport source (output valid, status, input ready);
    modport sink (input valid, status, output ready);
endinterface

FILE: src/gsb_cfg.sv
module gsb_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gsb_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [gsb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output gsb_pkg::cfg_t                     cfg
);
    import gsb_pkg::*;

    cfg_t cfg_reg;

    // register file write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_ZONE_MODE:  cfg_reg.zone_mode  <= cfg_wdata[1:0];
                CFG_SHIFT_MODE: cfg_reg.shift_mode <= cfg_wdata[1:0];
                CFG_WIN1_START: cfg_reg.win1_start <= cfg_wdata[ADDR_W-1:0];
                CFG_WIN1_END:   cfg_reg.win1_end   <= cfg_wdata[ADDR_W-1:0];
                CFG_WIN2_START: cfg_reg.win2_start <= cfg_wdata[ADDR_W-1:0];
                CFG_WIN2_END:   cfg_reg.win2_end   <= cfg_wdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/gsb_calc.sv
module gsb_calc #(
    parameter int WORD_BITS    = 32,
    parameter int BITMAP_WORDS = 2048
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  gsb_pkg::func_t                            req_func,
    input  logic [gsb_pkg::ADDR_W-1:0]                req_addr,
    input  logic [gsb_pkg::SIZE_W-1:0]                req_size,
    input  gsb_pkg::cfg_t                             cfg,
    output gsb_pkg::calc_stat_t                       stat,
    output gsb_pkg::func_t                            func_out,
    output logic [$clog2(BITMAP_WORDS)-1:0]           word,
    output logic [$clog2(WORD_BITS)-1:0]              bit_pos,
    output logic [gsb_pkg::IDX_W-1:0]                 count
);
    import gsb_pkg::*;

    localparam int AW      = $clog2(BITMAP_WORDS);
    localparam int BW      = $clog2(WORD_BITS);
    // reciprocal of WORD_BITS, exact for every 16-bit granule index
    localparam int DIV_S   = IDX_W + BW;
    localparam int RECIP_W = DIV_S + 1;
    localparam int PROD_W  = IDX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << DIV_S) + longint'(WORD_BITS) - 1) / longint'(WORD_BITS));

    typedef enum logic [7:0] {
        C_IDLE  = 8'b0000_0001,
        C_WIN   = 8'b0000_0010,
        C_REMAP = 8'b0000_0100,
        C_BOUND = 8'b0000_1000,
        C_DIV   = 8'b0001_0000,
        C_REM   = 8'b0010_0000,
        C_WRAP  = 8'b0100_0000,
        C_DONE  = 8'b1000_0000
    } calc_state_t;

    calc_state_t       state_reg;
    func_t             func_reg;
    logic [ADDR_W:0]   addr_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              hit_reg;
    logic              reject_reg;
    status_t           status_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  count_reg;
    logic [IDX_W-1:0]  q_reg;
    logic [IDX_W-1:0]  word_reg;
    logic [BW-1:0]     bit_reg;

    logic [SIZE_W-1:0] gran_mask;
    logic [5:0]        gran_sh;
    logic              misalign;
    logic              win_on;
    logic [ADDR_W-1:0] win_start;
    logic [ADDR_W-1:0] win_end;
    logic [ADDR_W:0]   win_diff;
    logic              in_win;
    logic [ADDR_W+1:0] end_sum;
    logic              out_zone;
    logic [PROD_W-1:0] prod;

    // granule size per zone mode
    always_comb
    begin
        case (cfg.zone_mode)
            ZM_64K:  gran_mask = 32'h0000_FFFF;
            ZM_128K: gran_mask = 32'h0001_FFFF;
            default: gran_mask = 32'h0003_FFFF;
        endcase
    end

    assign gran_sh  = 6'(GRAN_SHIFT_MIN) + {4'b0, cfg.zone_mode};
    assign misalign = |(size_reg & gran_mask);

    // remap window select and hit test
    always_comb
    begin
        case (cfg.shift_mode)
            SM_WIN1:
            begin
                win_on    = 1'b1;
                win_start = cfg.win1_start;
                win_end   = cfg.win1_end;
            end
            SM_WIN2:
            begin
                win_on    = 1'b1;
                win_start = cfg.win2_start;
                win_end   = cfg.win2_end;
            end
            default:
            begin
                win_on    = 1'b0;
                win_start = '0;
                win_end   = '0;
            end
        endcase
    end

    assign win_diff = {1'b0, addr_reg[ADDR_W-1:0]} - {1'b0, win_start};
    assign in_win   = win_on && !win_diff[ADDR_W] && (addr_reg[ADDR_W-1:0] < win_end);

    // zone limit test on start and end
    assign end_sum = {1'b0, addr_reg} + (ADDR_W+2)'(size_reg);

    always_comb
    begin
        case (cfg.zone_mode)
            ZM_64K:  out_zone = (|addr_reg[ADDR_W:ZONE_SHIFT_MIN])
                             || (|end_sum[ADDR_W+1:ZONE_SHIFT_MIN]);
            ZM_128K: out_zone = (|addr_reg[ADDR_W:ZONE_SHIFT_MIN+1])
                             || (|end_sum[ADDR_W+1:ZONE_SHIFT_MIN+1]);
            default: out_zone = (|addr_reg[ADDR_W:ZONE_SHIFT_MIN+2])
                             || (|end_sum[ADDR_W+1:ZONE_SHIFT_MIN+2]);
        endcase
    end

    // granule index divided by the word width
    assign prod = PROD_W'(idx_reg) * PROD_W'(RECIP);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                        state_reg <= C_WIN;
                end
                C_WIN:
                begin
                    if (cfg.zone_mode == ZM_NONE || misalign)
                        state_reg <= C_DONE;
                    else
                        state_reg <= C_REMAP;
                end
                C_REMAP: state_reg <= C_BOUND;
                C_BOUND:
                begin
                    if (out_zone || size_reg == '0 || func_reg == FN_BAD)
                        state_reg <= C_DONE;
                    else
                        state_reg <= C_DIV;
                end
                C_DIV: state_reg <= C_REM;
                C_REM: state_reg <= C_WRAP;
                C_WRAP:
                begin
                    if ({1'b0, word_reg} < (IDX_W+1)'(BITMAP_WORDS))
                        state_reg <= C_DONE;
                end
                C_DONE: state_reg <= C_IDLE;
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    func_reg   <= req_func;
                    addr_reg   <= {1'b0, req_addr};
                    size_reg   <= req_size;
                    reject_reg <= 1'b0;
                    status_reg <= STS_OK;
                end
            end
            C_WIN:
            begin
                if (cfg.zone_mode == ZM_NONE)
                begin
                    reject_reg <= 1'b1;
                    status_reg <= STS_RANGE;
                end
                else if (misalign)
                begin
                    reject_reg <= 1'b1;
                    status_reg <= STS_MISALIGN;
                end
                hit_reg <= in_win;
                if (in_win)
                    addr_reg <= win_diff;
            end
            C_REMAP:
            begin
                if (hit_reg)
                    addr_reg <= addr_reg + REMAP_BASE;
            end
            C_BOUND:
            begin
                if (out_zone || size_reg == '0)
                begin
                    reject_reg <= 1'b1;
                    status_reg <= STS_RANGE;
                end
                else if (func_reg == FN_BAD)
                begin
                    reject_reg <= 1'b1;
                    status_reg <= STS_BADOP;
                end
                idx_reg   <= IDX_W'(addr_reg >> gran_sh);
                count_reg <= IDX_W'(size_reg >> gran_sh);
            end
            C_DIV:
            begin
                q_reg <= IDX_W'(prod >> DIV_S);
            end
            C_REM:
            begin
                word_reg <= q_reg;
                bit_reg  <= BW'(idx_reg - IDX_W'(q_reg * IDX_W'(WORD_BITS)));
            end
            C_WRAP:
            begin
                // word index wraps around the bitmap depth
                if ({1'b0, word_reg} >= (IDX_W+1)'(BITMAP_WORDS))
                    word_reg <= word_reg - IDX_W'(BITMAP_WORDS);
            end
            default: ;
        endcase
    end

    assign stat.done   = (state_reg == C_DONE);
    assign stat.reject = reject_reg;
    assign stat.status = status_reg;
    assign func_out    = func_reg;
    assign word        = word_reg[AW-1:0];
    assign bit_pos     = bit_reg;
    assign count       = count_reg;

endmodule

FILE: src/gsb_walk.sv
module gsb_walk #(
    parameter int WORD_BITS    = 32,
    parameter int BITMAP_WORDS = 2048
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  gsb_pkg::func_t                    func,
    input  logic [$clog2(BITMAP_WORDS)-1:0]   word,
    input  logic [$clog2(WORD_BITS)-1:0]      bit_pos,
    input  logic [gsb_pkg::IDX_W-1:0]         count,
    output gsb_pkg::walk_stat_t               stat
);
    import gsb_pkg::*;

    localparam int AW = $clog2(BITMAP_WORDS);
    localparam int BW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] mem [BITMAP_WORDS];

    logic                 clearing_reg;
    logic [AW-1:0]        clr_ptr_reg;
    logic                 issue_reg;
    func_t                func_reg;
    logic [AW-1:0]        ptr_reg;
    logic [BW-1:0]        bit_reg;
    logic [IDX_W-1:0]     remain_reg;
    logic                 p2_valid_reg;
    logic [AW-1:0]        p2_addr_reg;
    logic [WORD_BITS-1:0] p2_mask_reg;
    logic                 p2_last_reg;
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [BW:0]          span;
    logic                 full;
    logic [BW:0]          end_pos;
    logic [WORD_BITS-1:0] mask_lo;
    logic [WORD_BITS-1:0] mask;
    logic [IDX_W-1:0]     remain_next;
    logic [AW-1:0]        ptr_next;
    logic                 fail;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // mask of the range bits in the word being issued
    assign span    = (BW+1)'(WORD_BITS) - (BW+1)'(bit_reg);
    assign full    = remain_reg >= IDX_W'(span);
    assign end_pos = (BW+1)'(bit_reg) + remain_reg[BW:0];
    assign mask_lo = {WORD_BITS{1'b1}} << bit_reg;
    assign mask    = full ? mask_lo : (mask_lo & ~({WORD_BITS{1'b1}} << end_pos));
    assign remain_next = full ? (remain_reg - IDX_W'(span)) : '0;
    assign ptr_next    = (ptr_reg == AW'(BITMAP_WORDS - 1)) ? '0 : (ptr_reg + 1'b1);

    // second stage: read data is back, check or write
    assign fail = p2_valid_reg && (func_reg == FN_CHK)
               && ((rd_data_reg & p2_mask_reg) != p2_mask_reg);

    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_ptr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = p2_valid_reg && (func_reg != FN_CHK);
            mem_waddr = p2_addr_reg;
            mem_wdata = (func_reg == FN_SET) ? (rd_data_reg | p2_mask_reg)
                                             : (rd_data_reg & ~p2_mask_reg);
        end
    end

    // bitmap storage, one write and one registered read per cycle;
    // the write of one word and the read of the next never share an address
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[ptr_reg];
    end

    // clearing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_ptr_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
            if (clr_ptr_reg == AW'(BITMAP_WORDS - 1))
                clearing_reg <= 1'b0;
        end
    end

    // word issue and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else if (start)
        begin
            issue_reg    <= 1'b1;
            p2_valid_reg <= 1'b0;
        end
        else if (fail)
        begin
            issue_reg    <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p2_valid_reg <= issue_reg;
            if (issue_reg && remain_next == '0)
                issue_reg <= 1'b0;
        end
    end

    // word issue payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            func_reg   <= func;
            ptr_reg    <= word;
            bit_reg    <= bit_pos;
            remain_reg <= count;
        end
        else if (issue_reg)
        begin
            p2_addr_reg <= ptr_reg;
            p2_mask_reg <= mask;
            p2_last_reg <= (remain_next == '0);
            ptr_reg     <= ptr_next;
            bit_reg     <= '0;
            remain_reg  <= remain_next;
        end
    end

    assign stat.clearing = clearing_reg;
    assign stat.done     = p2_valid_reg && (p2_last_reg || fail);
    assign stat.fail     = fail;

endmodule

FILE: src/granule_security_bitmap.sv
// A rejected request goes from the range calculator straight to the response
// register; an accepted range walks the bitmap words it covers, stopping early on a failed check.
// Throughput: one request at a time, one bitmap word read-modify-write per cycle
// through the bitmap memory's read and write ports; the next request can be taken
// in the cycle after the response loads.
// Reset: asynchronous, active low; afterwards a clearing pass writes zeros over
// the bitmap with ready held low; config regs reset to 0.
module granule_security_bitmap #(
    parameter int WORD_BITS    = 32,
    parameter int BITMAP_WORDS = 2048
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gsb_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [gsb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    gsb_req_if.sink                           req,
    gsb_rsp_if.source                         rsp
);
    import gsb_pkg::*;

    localparam int AW = $clog2(BITMAP_WORDS);
    localparam int BW = $clog2(WORD_BITS);

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_CALC = 4'b0010,
        T_WALK = 4'b0100,
        T_RESP = 4'b1000
    } top_state_t;

    top_state_t       state_reg;
    status_t          hold_status_reg;
    logic             rsp_valid_reg;
    status_t          rsp_status_reg;

    cfg_t             cfg;
    calc_stat_t       cstat;
    walk_stat_t       wstat;
    func_t            calc_func;
    logic [AW-1:0]    calc_word;
    logic [BW-1:0]    calc_bit;
    logic [IDX_W-1:0] calc_count;
    logic             accept;
    logic             walk_start;
    logic             rsp_load;

    assign req.ready  = (state_reg == T_IDLE) && !wstat.clearing;
    assign accept     = req.valid && req.ready;
    assign walk_start = (state_reg == T_CALC) && cstat.done && !cstat.reject;
    assign rsp_load   = (state_reg == T_RESP) && (!rsp_valid_reg || rsp.ready);

    gsb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gsb_calc #(
        .WORD_BITS    (WORD_BITS),
        .BITMAP_WORDS (BITMAP_WORDS)
    ) u_calc (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .req_func (req.func),
        .req_addr (req.phys_addr),
        .req_size (req.size_bytes),
        .cfg      (cfg),
        .stat     (cstat),
        .func_out (calc_func),
        .word     (calc_word),
        .bit_pos  (calc_bit),
        .count    (calc_count)
    );

    gsb_walk #(
        .WORD_BITS    (WORD_BITS),
        .BITMAP_WORDS (BITMAP_WORDS)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (walk_start),
        .func    (calc_func),
        .word    (calc_word),
        .bit_pos (calc_bit),
        .count   (calc_count),
        .stat    (wstat)
    );

    // request sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            unique case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                        state_reg <= T_CALC;
                end
                T_CALC:
                begin
                    if (cstat.done)
                        state_reg <= cstat.reject ? T_RESP : T_WALK;
                end
                T_WALK:
                begin
                    if (wstat.done)
                        state_reg <= T_RESP;
                end
                T_RESP:
                begin
                    if (rsp_load)
                        state_reg <= T_IDLE;
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    // final status of the request in flight
    always_ff @(posedge clk)
    begin
        if (state_reg == T_CALC && cstat.done)
            hold_status_reg <= cstat.status;
        else if (state_reg == T_WALK && wstat.done)
            hold_status_reg <= wstat.fail ? STS_CHKFAIL : STS_OK;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (rsp_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
            rsp_status_reg <= hold_status_reg;
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_status_reg;

endmodule

FILE: src/gsb_checker.sv
module gsb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] rsp_status
);

    // a stalled response holds its status
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
        else $error("response dropped or changed while stalled");

    // ready is low right after reset, while the bitmap clearing starts
    a_clear_block: assert property (@(posedge clk)
        $past(!rst_n) |-> !req_ready)
        else $error("request ready right after reset");

    // one request in flight at a time
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while busy");

    // a response never appears in the cycle after a request is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("response faster than the range check allows");

endmodule

bind granule_security_bitmap gsb_checker u_gsb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status)
);
